[src/qph_pkg.sv]
// ----------------------------------------------------------------------------
// qph_pkg
// Shared types and constants for the quadratic-probe hash table.
// ----------------------------------------------------------------------------
package qph_pkg;

    localparam int SLOTS_DEF  = 256;
    localparam int CAP_W      = 9;
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int HASH_SHIFT = 16;
    localparam int HASH_W     = 2 * KEY_W - HASH_SHIFT;
    localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;

    // Index arithmetic width: holds any slot index, the capacity and their sum.
    function automatic int idx_arith_w(input int slots);
        int iw;
        iw = $clog2(slots);
        return ((iw > CAP_W) ? iw : CAP_W) + 1;
    endfunction

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_GET    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_USED    = 2'd1,
        MARK_DELETED = 2'd2
    } mark_t;

endpackage

[src/qph_hash.sv]
// ----------------------------------------------------------------------------
// qph_hash
// Home slot unit: multiplicative hash, then remainder by the capacity,
// eight quotient bits per cycle.
// ----------------------------------------------------------------------------
module qph_hash #(
    parameter int AW = qph_pkg::idx_arith_w(qph_pkg::SLOTS_DEF)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [qph_pkg::KEY_W-1:0] key,
    input  logic [AW-1:0]             cap,
    output logic                      done,
    output logic [AW-1:0]             home
);
    import qph_pkg::*;

    localparam int STEP_BITS = 8;
    localparam int MOD_CYC   = HASH_W / STEP_BITS;
    localparam int CNT_W     = $clog2(MOD_CYC);

    typedef enum logic [1:0] {H_IDLE, H_MUL, H_FIX, H_MOD} hstate_t;

    hstate_t                 state_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [AW-1:0]           cap_reg;
    logic [2*KEY_W-1:0]      prod_reg;
    logic [HASH_W-1:0]       quo_reg;
    logic [AW-1:0]           rem_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    done_reg;
    logic [AW-1:0]           home_reg;
    logic [AW-1:0]           rem_next;

    // Restoring remainder over the top byte of the shifting quotient word.
    always_comb begin
        logic [AW-1:0] t;
        t = rem_reg;
        for (int i = 0; i < STEP_BITS; i++) begin
            t = {t[AW-2:0], quo_reg[HASH_W-1-i]};
            if (t >= cap_reg) begin
                t = t - cap_reg;
            end
        end
        rem_next = t;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == H_MOD) && (cnt_reg == CNT_W'(MOD_CYC - 1));
            case (state_reg)
                H_IDLE: begin
                    if (start) begin
                        key_reg   <= key;
                        cap_reg   <= cap;
                        state_reg <= H_MUL;
                    end
                end
                H_MUL: begin
                    prod_reg  <= {{KEY_W{1'b0}}, key_reg} * {{KEY_W{1'b0}}, HASH_MULT};
                    state_reg <= H_FIX;
                end
                H_FIX: begin
                    // sign extension of the key subtracts mult << 32
                    quo_reg   <= prod_reg[2*KEY_W-1:HASH_SHIFT]
                               - (key_reg[KEY_W-1] ? {HASH_MULT, {HASH_SHIFT{1'b0}}}
                                                   : {HASH_W{1'b0}});
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= H_MOD;
                end
                H_MOD: begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_reg << STEP_BITS;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(MOD_CYC - 1)) begin
                        home_reg  <= rem_next;
                        state_reg <= H_IDLE;
                    end
                end
                default: state_reg <= H_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign home = home_reg;

    home_below_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> home_reg < cap_reg)
        else $error("home slot not below capacity");

    done_after_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(state_reg) == H_MOD)
        else $error("done without remainder pass");

    start_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == H_MUL) |-> $past(state_reg) == H_IDLE)
        else $error("multiply entered from wrong state");

endmodule

[src/quadratic_probe_hash_table_top.sv]
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_top
// Open-addressing hash table with quadratic probing, one request per item.
// ----------------------------------------------------------------------------
// One item at a time. After reset the slot memory is swept to empty, slot by
// slot, with s_tready low. An item then passes an accept step, home-slot
// hashing (multiply, sign fix, six remainder steps), a read of the slot memory
// and then a compare for each slot probed, and a finish step that, once the
// result register is free, writes back and loads the result register. At most
// SLOTS slots are probed. A put on a full table and the unused command skip
// probing. The result register lets the next item in while a result waits.
module quadratic_probe_hash_table_top #(
    parameter int SLOTS = qph_pkg::SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,   // capacity_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // key[31:0], value[63:32]
    input  logic [1:0]  s_tuser,     // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,     // found_value[31:0], entry_count_out[40:32]
    output logic [2:0]  m_tuser      // status
);
    import qph_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int AW = idx_arith_w(SLOTS);
    localparam int SW = $clog2(SLOTS + 1);
    localparam int MW = 2 + KEY_W + VAL_W;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HASH, S_PROBE, S_CHECK, S_FINISH} state_t;

    state_t             state_reg;
    logic [CAP_W-1:0]   cfg_reg;
    logic [IW-1:0]      clr_reg;
    cmd_t               cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [AW-1:0]      cap_reg;
    logic [AW-1:0]      home_reg;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      d_reg;
    logic [SW-1:0]      s_reg;
    logic               full_reg;
    logic               hit_reg;
    logic               del_reg;
    logic               empty_reg;
    logic [AW-1:0]      del_idx_reg;
    logic [AW-1:0]      free_idx_reg;
    logic [CAP_W-1:0]   count_reg;
    logic               m_tvalid_reg;
    logic [2:0]         status_reg;
    logic [VAL_W-1:0]   fval_reg;
    logic [MW-1:0]      rdata_reg;

    logic [MW-1:0]      mem [SLOTS];
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [MW-1:0]      mem_wdata;

    logic [AW-1:0]      cap_eff;
    logic               accept;
    logic               hash_done;
    logic [AW-1:0]      hash_home;
    logic [AW-1:0]      idx_sum, idx_adv, d_two, d_one, d_adv;
    logic [1:0]         rd_mark;
    logic               out_free;
    status_t            status_new;
    logic [CAP_W-1:0]   count_new;

    assign cap_eff = (cfg_reg == '0) ? AW'(1)
                   : ((AW'(cfg_reg) > AW'(SLOTS)) ? AW'(SLOTS) : AW'(cfg_reg));
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign rd_mark  = rdata_reg[MW-1 -: 2];

    qph_hash #(.AW(AW)) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .key     (s_tdata[KEY_W-1:0]),
        .cap     (cap_eff),
        .done    (hash_done),
        .home    (hash_home)
    );

    // next probe: idx += 2s+1, step grows by 2, both kept below capacity
    always_comb begin
        idx_sum = idx_reg + d_reg;
        idx_adv = (idx_sum >= cap_reg) ? idx_sum - cap_reg : idx_sum;
        d_two   = d_reg + AW'(2);
        d_one   = (d_two >= cap_reg) ? d_two - cap_reg : d_two;
        d_adv   = (d_one >= cap_reg) ? d_one - cap_reg : d_one;
    end

    always_comb begin
        status_new = ST_NOT_FOUND;
        count_new  = count_reg;
        mem_we     = 1'b0;
        mem_waddr  = clr_reg;
        mem_wdata  = {MARK_EMPTY, {(KEY_W + VAL_W){1'b0}}};
        if (state_reg == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (state_reg == S_FINISH) begin
            case (cmd_reg)
                CMD_PUT: begin
                    mem_wdata = {MARK_USED, key_reg, val_reg};
                    if (full_reg) begin
                        status_new = ST_FULL;
                    end else if (hit_reg) begin
                        status_new = ST_UPDATED;
                        mem_we     = out_free;
                        mem_waddr  = idx_reg[IW-1:0];
                    end else if (del_reg || empty_reg) begin
                        status_new = ST_INSERTED;
                        count_new  = count_reg + 1'b1;
                        mem_we     = out_free;
                        mem_waddr  = del_reg ? del_idx_reg[IW-1:0] : free_idx_reg[IW-1:0];
                    end else begin
                        status_new = ST_FULL;
                    end
                end
                CMD_GET: begin
                    if (hit_reg) begin
                        status_new = ST_FOUND;
                    end
                end
                CMD_REMOVE: begin
                    mem_wdata = {MARK_DELETED, key_reg, val_reg};
                    if (hit_reg) begin
                        status_new = ST_REMOVED;
                        mem_we     = out_free;
                        mem_waddr  = idx_reg[IW-1:0];
                        if (count_reg != '0) begin
                            count_new = count_reg - 1'b1;
                        end
                    end
                end
                default: status_new = ST_NOT_FOUND;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_PROBE) begin
            rdata_reg <= mem[idx_reg[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            cfg_reg      <= 9'd256;
            clr_reg      <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cfg_reg <= cfg_wdata;
            end
            if (state_reg == S_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == IW'(SLOTS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        cmd_reg   <= cmd_t'(s_tuser);
                        key_reg   <= s_tdata[KEY_W-1:0];
                        val_reg   <= s_tdata[KEY_W +: VAL_W];
                        cap_reg   <= cap_eff;
                        state_reg <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        home_reg  <= hash_home;
                        idx_reg   <= hash_home;
                        d_reg     <= (cap_reg == AW'(1)) ? '0 : AW'(1);
                        s_reg     <= '0;
                        hit_reg   <= 1'b0;
                        del_reg   <= 1'b0;
                        empty_reg <= 1'b0;
                        full_reg  <= (cmd_reg == CMD_PUT) && (AW'(count_reg) >= cap_reg);
                        if (cmd_reg == CMD_NONE
                            || ((cmd_reg == CMD_PUT) && (AW'(count_reg) >= cap_reg))) begin
                            state_reg <= S_FINISH;
                        end else begin
                            state_reg <= S_PROBE;
                        end
                    end
                end
                S_PROBE: begin
                    if ((s_reg != '0 && idx_reg == home_reg) || s_reg == SW'(SLOTS)) begin
                        state_reg <= S_FINISH;
                    end else begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (rd_mark == MARK_EMPTY) begin
                        empty_reg    <= 1'b1;
                        free_idx_reg <= idx_reg;
                        state_reg    <= S_FINISH;
                    end else if (rd_mark == MARK_USED
                                 && rdata_reg[VAL_W +: KEY_W] == key_reg) begin
                        hit_reg   <= 1'b1;
                        state_reg <= S_FINISH;
                    end else begin
                        if (rd_mark != MARK_USED && !del_reg) begin
                            del_reg     <= 1'b1;
                            del_idx_reg <= idx_reg;
                        end
                        idx_reg   <= idx_adv;
                        d_reg     <= d_adv;
                        s_reg     <= s_reg + 1'b1;
                        state_reg <= S_PROBE;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        count_reg    <= count_new;
                        status_reg   <= status_new;
                        fval_reg     <= (status_new == ST_FOUND) ? rdata_reg[VAL_W-1:0] : '0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, count_reg, fval_reg};

    count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> count_reg == $past(count_reg)
            || count_reg == $past(count_reg) + 1'b1
            || count_reg == $past(count_reg) - 1'b1)
        else $error("entry count moved by more than one");

    probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE || state_reg == S_CHECK) |-> idx_reg < cap_reg && d_reg < cap_reg)
        else $error("probe index out of range");

    no_write_while_probing: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE || state_reg == S_CHECK || state_reg == S_HASH) |-> !mem_we)
        else $error("slot write during probe");

    result_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_FINISH)
        else $error("result outside finish");

endmodule
